@@ rtl/core/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, register codes, reset values and the CORDIC arctangent table
// for the differential drive odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

  // Default values of the top level parameters.
  localparam int unsigned HEADING_BITS_DEF = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic {
    REG_HALF_WHEEL_RADIUS = 1'b0,
    REG_TURN_GAIN         = 1'b1
  } odo_reg_e;

  localparam logic [15:0] HALF_WHEEL_RADIUS_RST = 16'd1966;
  localparam logic [23:0] TURN_GAIN_RST         = 24'd400527;

  // CORDIC constants: Q4.30 start value folding in the rotation gain, and the
  // width of the iteration index (the table holds 24 entries).
  localparam int unsigned ATAN_LEN   = 24;
  localparam int unsigned ITER_IDX_W = 5;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] left_wheel_delta;
    logic signed [15:0] right_wheel_delta;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [23:0]        heading;
    logic [31:0]        path_distance;
  } odo_out_t;

  typedef struct packed {
    logic [15:0] half_wheel_radius;
    logic [23:0] turn_gain;
  } odo_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  load_in;
    logic                  upd_heading;
    logic                  upd_step;
    logic                  cordic_init;
    logic                  cordic_iter;
    logic                  do_round;
    logic                  upd_x;
    logic                  upd_y;
    logic                  publish;
    logic [ITER_IDX_W-1:0] iter;
  } odo_cmd_t;

  // Arctangent of 2^-i as a fraction of a 32-bit turn.
  function automatic logic [31:0] atan_turn(input logic [ITER_IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/odo_cfg.sv @@
// ----------------------------------------------------------------------------
// Odometry configuration registers
// APB-style register file holding the half wheel radius and the turn gain.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [odo_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [odo_pkg::PDATA_W-1:0]   pwdata,
  output logic      [odo_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output odo_pkg::odo_cfg_t                  cfg_o
);
  import odo_pkg::*;

  logic [15:0] half_wheel_radius_q;
  logic [23:0] turn_gain_q;
  logic        wr_en;
  odo_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = odo_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_wheel_radius_q <= HALF_WHEEL_RADIUS_RST;
      turn_gain_q         <= TURN_GAIN_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_HALF_WHEEL_RADIUS: half_wheel_radius_q <= pwdata[15:0];
        REG_TURN_GAIN:         turn_gain_q         <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HALF_WHEEL_RADIUS: prdata = PDATA_W'(half_wheel_radius_q);
      REG_TURN_GAIN:         prdata = PDATA_W'(turn_gain_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.half_wheel_radius = half_wheel_radius_q;
  assign cfg_o.turn_gain         = turn_gain_q;

endmodule

`default_nettype wire

@@ rtl/core/odo_ctrl.sv @@
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences one word through the heading, step length, CORDIC, position and
// distance updates, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_ctrl #(
  parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output odo_pkg::odo_cmd_t cmd_o
);
  import odo_pkg::*;

  localparam int unsigned ITER_W = $clog2(CORDIC_STEPS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_STEP,
    ST_INIT,
    ST_ITER,
    ST_ROUND,
    ST_POSX,
    ST_POSY,
    ST_PUB
  } state_e;

  state_e            state_q;
  logic [ITER_W-1:0] iter_q;
  logic              out_valid_q;
  logic              accept;
  logic              publish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  // The result register may be reloaded in the cycle its old word is taken.
  assign publish     = (state_q == ST_PUB) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !publish) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD:  state_q <= ST_STEP;
        ST_STEP:  state_q <= ST_INIT;
        ST_INIT: begin
          iter_q  <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          if (iter_q == ITER_LAST) begin
            state_q <= ST_ROUND;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_ROUND: state_q <= ST_POSX;
        ST_POSX:  state_q <= ST_POSY;
        ST_POSY:  state_q <= ST_PUB;
        ST_PUB: begin
          if (publish) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.load_in     = accept;
    cmd_o.upd_heading = (state_q == ST_HEAD);
    cmd_o.upd_step    = (state_q == ST_STEP);
    cmd_o.cordic_init = (state_q == ST_INIT);
    cmd_o.cordic_iter = (state_q == ST_ITER);
    cmd_o.do_round    = (state_q == ST_ROUND);
    cmd_o.upd_x       = (state_q == ST_POSX);
    cmd_o.upd_y       = (state_q == ST_POSY);
    cmd_o.publish     = publish;
    cmd_o.iter        = ITER_IDX_W'(iter_q);
  end

endmodule

`default_nettype wire

@@ rtl/core/odo_dp.sv @@
// ----------------------------------------------------------------------------
// Odometry datapath
// Accumulators, one shared multiplier, an iterative CORDIC rotator and the
// result register, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_dp #(
  parameter int unsigned HEADING_BITS = odo_pkg::HEADING_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire odo_pkg::odo_cmd_t cmd_i,
  input  wire odo_pkg::odo_cfg_t cfg_i,
  input  wire odo_pkg::odo_in_t  in_data_i,
  output odo_pkg::odo_out_t      out_data_o
);
  import odo_pkg::*;

  // Accumulated state.
  logic [HEADING_BITS-1:0] heading_q;
  logic signed [31:0]      x_q, y_q;
  logic [31:0]             dist_q;

  // Working registers.
  logic signed [16:0] diff_q, sum_q;
  logic signed [21:0] s_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [1:0]         quad_q;
  logic signed [15:0] cos_q, sin_q;
  odo_out_t           out_q;

  // Shared multiplier.
  logic signed [24:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [46:0] prod;

  always_comb begin
    mul_a = 25'(signed'({1'b0, cfg_i.turn_gain}));
    mul_b = 22'(diff_q);
    if (cmd_i.upd_step) begin
      mul_a = 25'(signed'({1'b0, cfg_i.half_wheel_radius}));
      mul_b = 22'(sum_q);
    end else if (cmd_i.upd_x) begin
      mul_a = 25'(cos_q);
      mul_b = s_q;
    end else if (cmd_i.upd_y) begin
      mul_a = 25'(sin_q);
      mul_b = s_q;
    end
  end

  assign prod = 47'(mul_a) * 47'(mul_b);

  // Rounded scalings of the product.
  logic signed [46:0]      prod_r12, prod_r15;
  logic [HEADING_BITS-1:0] head_step;
  logic signed [31:0]      pos_delta;
  logic signed [21:0]      step_len;

  assign prod_r12  = prod + 47'sd2048;
  assign prod_r15  = prod + 47'sd16384;
  assign head_step = prod_r12[12 +: HEADING_BITS];
  assign step_len  = prod_r12[33:12];
  assign pos_delta = prod_r15[46:15];

  // Saturating position update, shared by x and y.
  logic signed [31:0] pos_old;
  logic signed [32:0] pos_sum;
  logic signed [31:0] pos_sat;

  assign pos_old = cmd_i.upd_y ? y_q : x_q;
  assign pos_sum = 33'(pos_old) + 33'(pos_delta);

  always_comb begin
    if (pos_sum > 33'sd2147483647) begin
      pos_sat = 32'sh7fff_ffff;
    end else if (pos_sum < -33'sd2147483648) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  // Distance grows by the magnitude of the step and holds at full scale.
  logic [21:0] abs_s;
  logic [32:0] dist_sum;
  logic [31:0] dist_sat;

  assign abs_s    = s_q[21] ? 22'(-s_q) : 22'(s_q);
  assign dist_sum = {1'b0, dist_q} + 33'(abs_s);
  assign dist_sat = dist_sum[32] ? 32'hffff_ffff : dist_sum[31:0];

  // CORDIC set-up: split the angle into the nearest quarter turn and a
  // residual of at most an eighth of a turn either way.
  logic [31:0] ang32, ang_bias, ang_res;
  logic [1:0]  quad;

  assign ang32    = 32'(heading_q) << (32 - HEADING_BITS);
  assign ang_bias = ang32 + 32'h2000_0000;
  assign quad     = ang_bias[31:30];
  assign ang_res  = ang32 - {quad, 30'd0};

  // One CORDIC rotation step.
  logic signed [33:0] xs, ys, cx_d, cy_d;
  logic signed [32:0] atan_v, cz_d;

  assign xs     = cx_q >>> cmd_i.iter;
  assign ys     = cy_q >>> cmd_i.iter;
  assign atan_v = 33'(atan_turn(cmd_i.iter));

  always_comb begin
    if (!cz_q[32]) begin
      cx_d = cx_q - ys;
      cy_d = cy_q + xs;
      cz_d = cz_q - atan_v;
    end else begin
      cx_d = cx_q + ys;
      cy_d = cy_q - xs;
      cz_d = cz_q + atan_v;
    end
  end

  // Rounding to Q1.15 and folding the quadrant back in.
  logic signed [33:0] cx_r, cy_r;
  logic signed [19:0] c_rnd, s_rnd, tc, ts;

  assign cx_r  = cx_q + 34'sd16384;
  assign cy_r  = cy_q + 34'sd16384;
  assign c_rnd = 20'(cx_r >>> 15);
  assign s_rnd = 20'(cy_r >>> 15);

  always_comb begin
    case (quad_q)
      2'd0: begin
        tc = c_rnd;
        ts = s_rnd;
      end
      2'd1: begin
        tc = -s_rnd;
        ts = c_rnd;
      end
      2'd2: begin
        tc = -c_rnd;
        ts = -s_rnd;
      end
      default: begin
        tc = s_rnd;
        ts = -c_rnd;
      end
    endcase
  end

  function automatic logic signed [15:0] clamp16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      dist_q    <= '0;
    end else begin
      if (cmd_i.upd_heading) begin
        heading_q <= heading_q + head_step;
      end
      if (cmd_i.upd_x) begin
        x_q <= pos_sat;
      end
      if (cmd_i.upd_y) begin
        y_q    <= pos_sat;
        dist_q <= dist_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      diff_q <= 17'(in_data_i.right_wheel_delta) - 17'(in_data_i.left_wheel_delta);
      sum_q  <= 17'(in_data_i.right_wheel_delta) + 17'(in_data_i.left_wheel_delta);
    end
    if (cmd_i.upd_step) begin
      s_q <= step_len;
    end
    if (cmd_i.cordic_init) begin
      cx_q   <= CORDIC_GAIN_Q30;
      cy_q   <= '0;
      cz_q   <= 33'(signed'(ang_res));
      quad_q <= quad;
    end else if (cmd_i.cordic_iter) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
    if (cmd_i.do_round) begin
      cos_q <= clamp16(tc);
      sin_q <= clamp16(ts);
    end
    if (cmd_i.publish) begin
      out_q.pos_x         <= x_q;
      out_q.pos_y         <= y_q;
      out_q.heading       <= 24'(heading_q);
      out_q.path_distance <= dist_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ rtl/core/differential_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning position, heading and path length from wheel angle steps.
// ----------------------------------------------------------------------------
// Each word of wheel angle changes yields one result word, worked out by
// the iterative CORDIC, which resolves one rotation step per cycle, and by
// the single multiplier that is shared in turn by the heading, step length,
// x and y updates. One word is worked on at a time, so no new word is taken
// until the previous result has been loaded into the output register, but a
// new word is taken while the previous result still waits there. The
// heading, position and distance accumulators start at zero after reset; the
// two configuration registers should be written only while no word is in
// flight.
`default_nettype none

module differential_drive_odometry #(
  parameter int unsigned HEADING_BITS = odo_pkg::HEADING_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire odo_pkg::odo_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output odo_pkg::odo_out_t                out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [odo_pkg::PADDR_W-1:0] paddr,
  input  wire logic [odo_pkg::PDATA_W-1:0] pwdata,
  output logic      [odo_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import odo_pkg::*;

  odo_cfg_t cfg;
  odo_cmd_t cmd;

  odo_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  odo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  odo_dp #(
    .HEADING_BITS (HEADING_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // Only one datapath update is commanded in any cycle.
  a_single_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.upd_heading, cmd.upd_step, cmd.cordic_init, cmd.cordic_iter,
              cmd.do_round, cmd.upd_x, cmd.upd_y, cmd.publish}))
    else $error("more than one datapath update in a cycle");

  // A word is worked on alone: no second word is taken straight after one.
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a word is in flight");

  // Loading the result register always presents it on the next cycle.
  a_publish_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> out_valid_o)
    else $error("result loaded but not presented");

endmodule

`default_nettype wire
